// ===== rtl/sclip_pkg.sv =====
// Package of the serial command-line interpreter: key codes, command names,
// result and beat types. Used by every other file of the block.
package sclip_pkg;

    localparam int SCLIP_LINE_LEN = 96;
    localparam int CMD_COUNT      = 14;
    localparam int NAME_CHARS     = 13;
    localparam int WAIT_CYCLES    = CMD_COUNT + 2;

    localparam logic [7:0] KEY_ESC   = 8'h1B;
    localparam logic [7:0] KEY_CR    = 8'h0D;
    localparam logic [7:0] KEY_BS    = 8'h7F;
    localparam logic [7:0] KEY_BLANK = 8'h20;
    localparam logic [7:0] KEY_PLUS  = 8'h2B;
    localparam logic [7:0] KEY_MINUS = 8'h2D;
    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;
    localparam logic [7:0] KEY_WS_LO = 8'h09;
    localparam logic [7:0] KEY_WS_HI = 8'h0D;

    localparam logic [12:0] ARG_MAX   = 13'd5000;
    localparam logic [8:0]  DUTY_INIT = 9'd127;
    localparam logic [12:0] RECIP_MUL = 13'd5243;

    localparam logic [3:0] OP_RUN_ON   = 4'd0;
    localparam logic [3:0] OP_RUN_OFF  = 4'd1;
    localparam logic [3:0] OP_CHG_ON   = 4'd2;
    localparam logic [3:0] OP_CHG_OFF  = 4'd3;
    localparam logic [3:0] OP_SET_DUTY = 4'd10;
    localparam logic [3:0] OP_DIAG_ON  = 4'd13;

    localparam logic [8*NAME_CHARS-1:0] CMD_NAME [CMD_COUNT] = '{
        "start-it     ", "stop-it      ", "start-zu     ", "stop-zu      ",
        "version      ", "get-board-id ", "get-bat1     ", "get-bat2     ",
        "get-uost     ", "get-uosn     ", "set-uzt      ", "ustir-on     ",
        "ustir-off    ", "start-diagn  "
    };

    localparam logic [3:0] CMD_LEN [CMD_COUNT] = '{
        4'd8, 4'd7, 4'd8, 4'd7, 4'd7, 4'd12, 4'd8,
        4'd8, 4'd8, 4'd8, 4'd7, 4'd8, 4'd9, 4'd11
    };

    typedef struct packed {
        logic       v;
        logic       last;
        logic [7:0] ch;
    } t_beat;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic        send_newline;
        logic        cmd_valid;
        logic [3:0]  cmd_code;
        logic        cmd_unknown;
        logic        run_on;
        logic        charge_on;
        logic [8:0]  duty_value;
        logic [12:0] param_value;
        logic        diag_on;
        logic        diag_finish;
    } t_result;

endpackage

// ===== rtl/sclip_if.sv =====
// Channel interfaces of the interpreter: received bytes in, results out.
// Depends on sclip_pkg for the result type.
interface sclip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sclip_out_if import sclip_pkg::*;;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sclip_cell.sv =====
// One cell of the command matcher chain: compares the token stream with one
// command name and passes each beat on to the next cell. Uses sclip_pkg.
module sclip_cell import sclip_pkg::*; #(
    parameter int K = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_beat i_beat,
    output t_beat o_beat,
    output logic  o_hit
);
    logic [3:0] r_pos;
    logic       r_alive;
    logic       r_hit;
    t_beat      r_beat;
    logic [7:0] w_name_ch;

    assign w_name_ch = CMD_NAME[K][8*(NAME_CHARS-1-int'(r_pos)) +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_alive <= 1'b1;
            r_hit   <= 1'b0;
            r_beat  <= '0;
        end else begin
            r_beat <= i_beat;
            if (i_beat.v) begin
                if (i_beat.last) begin
                    r_hit   <= r_alive && (r_pos == CMD_LEN[K]);
                    r_alive <= 1'b1;
                    r_pos   <= '0;
                end else if (r_alive && (r_pos < CMD_LEN[K]) && (w_name_ch == i_beat.ch)) begin
                    r_pos <= r_pos + 4'd1;
                end else begin
                    r_alive <= 1'b0;
                end
            end
        end
    end

    assign o_beat = r_beat;
    assign o_hit  = r_hit;
endmodule

// ===== rtl/serial_command_line_interpreter.sv =====
// Serial command-line interpreter: line store, line walk, argument parser
// and output register. Uses sclip_pkg, sclip_if and sclip_cell.
//
// One received byte enters per beat on i_rx; each byte gives exactly one
// result beat on o_res. A byte other than Enter is stored or acted on at
// once and its result appears in the cycle after acceptance. Enter on a
// non-empty line walks the line store one character a cycle through the
// argument parser and into a chain of fourteen matcher cells, one per
// command name; the result follows once the line walk, the flush, the wait
// for the matcher chain and the duty division in S_DIV1 and S_DIV2 are done.
// A new byte is taken only when the block is idle and the output register
// is empty, so one byte is in flight at a time. While the receiver holds
// ready low the result stays in the output register and i_rx is not ready.
// After reset the line is empty, run, charge and diagnostic levels are low
// and the duty value is 127. The line store needs no clearing after reset.
module serial_command_line_interpreter import sclip_pkg::*; #(
    parameter int LINE_LEN = SCLIP_LINE_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sclip_in_if.sink      i_rx,
    sclip_out_if.source   o_res
);
    localparam int FW = $clog2(LINE_LEN + 1);
    localparam int AW = $clog2(LINE_LEN);

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_FLUSH, S_MATCH, S_DIV1, S_DIV2, S_DONE
    } t_state;

    typedef enum logic [1:0] {P_WS, P_DIG, P_DONE} t_parse;

    t_state      r_state;
    t_parse      r_phase;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_idx;
    logic        r_run;
    logic        r_charge;
    logic        r_diag;
    logic [8:0]  r_duty;
    logic        r_out_v;
    t_result     r_out;
    logic        r_rd_v;
    logic [7:0]  r_rdata;
    logic        r_tok_on;
    logic        r_arg_on;
    logic        r_eol;
    logic        r_neg;
    logic [12:0] r_val;
    logic [12:0] r_param;
    logic [5:0]  r_q;
    logic [8:0]  r_dnew;
    logic [4:0]  r_wait;
    t_beat       r_beat;
    logic        r_hit_any;
    logic [3:0]  r_code;

    logic [7:0]  mem [LINE_LEN];

    t_beat       w_beat [CMD_COUNT+1];
    logic [CMD_COUNT-1:0] w_hit;
    logic        w_accept;
    logic        w_store;
    logic        n_hit_any;
    logic [3:0]  n_code;
    logic [16:0] n_acc;
    logic        w_is_dig;
    logic [25:0] w_prod1;
    logic [18:0] w_prod2;

    assign w_accept = i_rx.valid && i_rx.ready;
    assign w_store  = w_accept && (i_rx.rx_byte != KEY_ESC) && (i_rx.rx_byte != KEY_CR)
                      && (i_rx.rx_byte != KEY_BS) && (r_fill < FW'(LINE_LEN));
    assign w_is_dig = (r_rdata >= KEY_ZERO) && (r_rdata <= KEY_NINE);
    assign n_acc    = 17'(r_val) * 17'd10 + 17'(r_rdata - KEY_ZERO);
    assign w_prod1  = 26'(r_param) * 26'(RECIP_MUL);
    assign w_prod2  = 19'(r_q) * 19'(RECIP_MUL);

    assign w_beat[0] = r_beat;
    for (genvar k = 0; k < CMD_COUNT; k++) begin : g_cell
        sclip_cell #(.K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_beat[k]),
            .o_beat  (w_beat[k+1]),
            .o_hit   (w_hit[k])
        );
    end

    always_comb begin
        n_hit_any = 1'b0;
        n_code    = '0;
        for (int k = CMD_COUNT - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                n_hit_any = 1'b1;
                n_code    = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem[r_fill[AW-1:0]] <= i_rx.rx_byte;
        end
        if (r_idx < r_fill) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= P_WS;
            r_fill    <= '0;
            r_idx     <= '0;
            r_run     <= 1'b0;
            r_charge  <= 1'b0;
            r_diag    <= 1'b0;
            r_duty    <= DUTY_INIT;
            r_out_v   <= 1'b0;
            r_rd_v    <= 1'b0;
            r_tok_on  <= 1'b0;
            r_arg_on  <= 1'b0;
            r_eol     <= 1'b0;
            r_neg     <= 1'b0;
            r_val     <= '0;
            r_wait    <= '0;
            r_beat    <= '0;
            r_hit_any <= 1'b0;
            r_code    <= '0;
        end else begin
            r_beat <= '0;
            if (r_out_v && o_res.ready) begin
                r_out_v <= 1'b0;
            end

            if (r_rd_v && !r_eol) begin
                if (r_rdata == 8'h00) begin
                    r_eol    <= 1'b1;
                    r_arg_on <= 1'b0;
                    if (r_tok_on) begin
                        r_tok_on <= 1'b0;
                        r_beat   <= '{v: 1'b1, last: 1'b1, ch: 8'h00};
                    end
                end else if (r_tok_on) begin
                    if (r_rdata == KEY_BLANK) begin
                        r_tok_on <= 1'b0;
                        r_arg_on <= 1'b1;
                        r_beat   <= '{v: 1'b1, last: 1'b1, ch: 8'h00};
                    end else begin
                        r_beat <= '{v: 1'b1, last: 1'b0, ch: r_rdata};
                    end
                end else if (r_arg_on) begin
                    if (r_rdata == KEY_BLANK) begin
                        r_arg_on <= 1'b0;
                    end else begin
                        case (r_phase)
                            P_WS: begin
                                if (w_is_dig) begin
                                    r_val   <= n_acc[12:0];
                                    r_phase <= P_DIG;
                                end else if (r_rdata == KEY_PLUS) begin
                                    r_phase <= P_DIG;
                                end else if (r_rdata == KEY_MINUS) begin
                                    r_neg   <= 1'b1;
                                    r_phase <= P_DIG;
                                end else if ((r_rdata < KEY_WS_LO) || (r_rdata > KEY_WS_HI)) begin
                                    r_phase <= P_DONE;
                                end
                            end
                            P_DIG: begin
                                if (w_is_dig) begin
                                    r_val <= (n_acc > 17'(ARG_MAX)) ? ARG_MAX : n_acc[12:0];
                                end else begin
                                    r_phase <= P_DONE;
                                end
                            end
                            default: begin
                                r_phase <= P_DONE;
                            end
                        endcase
                    end
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_out_v <= 1'b1;
                        r_out   <= '0;
                        r_out.run_on     <= r_run;
                        r_out.charge_on  <= r_charge;
                        r_out.duty_value <= r_duty;
                        r_out.diag_on    <= r_diag;
                        if (i_rx.rx_byte == KEY_ESC) begin
                            r_diag <= 1'b0;
                            r_out.diag_on     <= 1'b0;
                            r_out.diag_finish <= r_diag;
                        end else if (i_rx.rx_byte == KEY_CR) begin
                            r_out.send_newline <= 1'b1;
                            if (r_fill != '0) begin
                                r_out_v  <= 1'b0;
                                r_state  <= S_WALK;
                                r_idx    <= '0;
                                r_tok_on <= 1'b1;
                                r_arg_on <= 1'b0;
                                r_eol    <= 1'b0;
                                r_neg    <= 1'b0;
                                r_val    <= '0;
                                r_phase  <= P_WS;
                            end
                        end else begin
                            r_out.echo_valid <= 1'b1;
                            r_out.echo_byte  <= i_rx.rx_byte;
                            if (i_rx.rx_byte == KEY_BS) begin
                                if (r_fill != '0) begin
                                    r_fill <= r_fill - FW'(1);
                                end
                            end else if (r_fill < FW'(LINE_LEN)) begin
                                r_fill <= r_fill + FW'(1);
                            end
                        end
                    end
                end
                S_WALK: begin
                    if (r_idx < r_fill) begin
                        r_rd_v <= 1'b1;
                        r_idx  <= r_idx + FW'(1);
                    end else begin
                        r_rd_v <= 1'b0;
                        if (!r_rd_v) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (r_tok_on) begin
                        r_tok_on <= 1'b0;
                        r_beat   <= '{v: 1'b1, last: 1'b1, ch: 8'h00};
                    end
                    r_wait  <= '0;
                    r_param <= r_neg ? '0 : r_val;
                    r_state <= S_MATCH;
                end
                S_MATCH: begin
                    if (r_wait == 5'(WAIT_CYCLES)) begin
                        r_hit_any <= n_hit_any;
                        r_code    <= n_code;
                        r_state   <= S_DIV1;
                    end else begin
                        r_wait <= r_wait + 5'd1;
                    end
                end
                S_DIV1: begin
                    r_q     <= w_prod1[24:19];
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_dnew  <= w_prod2[18:10];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_fill  <= '0;
                    r_state <= S_IDLE;
                    r_out_v <= 1'b1;
                    r_out   <= '0;
                    r_out.send_newline <= 1'b1;
                    r_out.cmd_valid    <= r_hit_any;
                    r_out.cmd_code     <= r_hit_any ? r_code : 4'd0;
                    r_out.cmd_unknown  <= !r_hit_any;
                    r_out.run_on       <= r_run;
                    r_out.charge_on    <= r_charge;
                    r_out.duty_value   <= r_duty;
                    r_out.diag_on      <= r_diag;
                    if (r_hit_any) begin
                        case (r_code)
                            OP_RUN_ON: begin
                                r_run <= 1'b1;
                                r_out.run_on <= 1'b1;
                            end
                            OP_RUN_OFF: begin
                                r_run <= 1'b0;
                                r_out.run_on <= 1'b0;
                            end
                            OP_CHG_ON: begin
                                r_charge <= 1'b1;
                                r_out.charge_on <= 1'b1;
                            end
                            OP_CHG_OFF: begin
                                r_charge <= 1'b0;
                                r_out.charge_on <= 1'b0;
                            end
                            OP_DIAG_ON: begin
                                r_diag <= 1'b1;
                                r_out.diag_on <= 1'b1;
                            end
                            OP_SET_DUTY: begin
                                r_duty <= r_dnew;
                                r_out.duty_value  <= r_dnew;
                                r_out.param_value <= r_param;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_rx.ready  = (r_state == S_IDLE) && !r_out_v;
    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_LEN)) else $error("line fill count exceeds the line length");
    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.data.cmd_valid && o_res.data.cmd_unknown))
        else $error("a line is both matched and unknown");
    a_cmd_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.data.cmd_valid || o_res.data.cmd_unknown))
        |-> o_res.data.send_newline) else $error("verdict without Enter");
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !i_rx.ready) else $error("byte taken while a result is pending");
    a_walk_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_fill == '0)) else $error("line not cleared after Enter");
endmodule
